// ----- design/ujm_pkg.sv -----
// Shared types, constants and helpers for the undo journal memory.
// No dependencies; ujm_ctrl, ujm_dp and the top level import this package.
package ujm_pkg;

  localparam int unsigned JOURNAL_DEPTH = 256;
  localparam int unsigned ADDR_BITS     = 16;
  localparam int unsigned JIDX_W        = (JOURNAL_DEPTH > 1) ? $clog2(JOURNAL_DEPTH) : 1;
  localparam int unsigned MEM_DEPTH     = 1 << ADDR_BITS;
  localparam int unsigned NUM_W         = 32;

  typedef enum logic [2:0] {
    KIND_LOAD      = 3'd0,
    KIND_WRITE     = 3'd1,
    KIND_READ      = 3'd2,
    KIND_BEGIN     = 3'd3,
    KIND_END       = 3'd4,
    KIND_STEP_BACK = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_ACC   = 3'd0,
    REG_X     = 3'd1,
    REG_Y     = 3'd2,
    REG_SP    = 3'd3,
    REG_FLAGS = 3'd4,
    REG_PCH   = 3'd5,
    REG_PCL   = 3'd6
  } reg_code_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG_WR,
    ST_READ_OUT,
    ST_END_SCAN,
    ST_SB_WALK
  } state_e;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [15:0] pc;
  } regs_t;

  // is_reg set: loc holds a register code in its low bits
  typedef struct packed {
    logic                 is_reg;
    logic [ADDR_BITS-1:0] loc;
    logic [7:0]           old;
    logic [NUM_W-1:0]     num;
  } jentry_t;

  typedef struct packed {
    logic capture;
    logic mem_load;
    logic begin_instr;
    logic end_start;
    logic sb_start;
    logic log_write;
    logic emit_read;
    logic end_step;
    logic sb_step;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sb_stop;
  } stat_t;

  function automatic logic [7:0] reg_byte(input regs_t r, input reg_code_e c);
    logic [7:0] v;
    unique case (c)
      REG_ACC:   v = r.acc;
      REG_X:     v = r.x;
      REG_Y:     v = r.y;
      REG_SP:    v = r.sp;
      REG_FLAGS: v = r.flags;
      REG_PCH:   v = r.pc[15:8];
      REG_PCL:   v = r.pc[7:0];
      default:   v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic regs_t reg_put(input regs_t r, input reg_code_e c, input logic [7:0] v);
    regs_t o;
    o = r;
    unique case (c)
      REG_ACC:   o.acc       = v;
      REG_X:     o.x         = v;
      REG_Y:     o.y         = v;
      REG_SP:    o.sp        = v;
      REG_FLAGS: o.flags     = v;
      REG_PCH:   o.pc[15:8]  = v;
      REG_PCL:   o.pc[7:0]   = v;
      default:   o           = r;
    endcase
    return o;
  endfunction

  function automatic logic [JIDX_W-1:0] jidx_next(input logic [JIDX_W-1:0] i);
    return (i == JIDX_W'(JOURNAL_DEPTH - 1)) ? '0 : i + JIDX_W'(1);
  endfunction

  function automatic logic [JIDX_W-1:0] jidx_prev(input logic [JIDX_W-1:0] i);
    return (i == '0) ? JIDX_W'(JOURNAL_DEPTH - 1) : i - JIDX_W'(1);
  endfunction

endpackage

// ----- design/ujm_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ujm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/ujm_ctrl.sv -----
// Controller state machine: sequences each transaction and drives datapath commands.
// Depends on ujm_pkg.
module ujm_ctrl import ujm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] kind_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;
  kind_e  kind;
  logic   accept;

  assign kind   = kind_e'(kind_i);
  assign accept = start_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (kind)
            KIND_WRITE:     state_d = ST_LOG_WR;
            KIND_READ:      state_d = ST_READ_OUT;
            KIND_END:       state_d = ST_END_SCAN;
            KIND_STEP_BACK: state_d = ST_SB_WALK;
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOG_WR:   state_d = ST_IDLE;
      ST_READ_OUT: state_d = ST_IDLE;
      ST_END_SCAN: state_d = stat_i.scan_last ? ST_IDLE : ST_END_SCAN;
      ST_SB_WALK:  state_d = stat_i.sb_stop ? ST_IDLE : ST_SB_WALK;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.capture     = accept;
    cmd_o.mem_load    = accept && (kind == KIND_LOAD);
    cmd_o.begin_instr = accept && (kind == KIND_BEGIN);
    cmd_o.end_start   = accept && (kind == KIND_END);
    cmd_o.sb_start    = accept && (kind == KIND_STEP_BACK);
    cmd_o.log_write   = (state_q == ST_LOG_WR);
    cmd_o.emit_read   = (state_q == ST_READ_OUT);
    cmd_o.end_step    = (state_q == ST_END_SCAN);
    cmd_o.sb_step     = (state_q == ST_SB_WALK);
    busy_o            = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/ujm_dp.sv -----
// Datapath: byte memory, journal ring with per-entry valid bits, register
// snapshots, instruction counter and result registers. Depends on ujm_pkg, ujm_ram.
module ujm_dp import ujm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  regs_t       regs_i,
  output logic        strobe_o,
  output logic        result_kind_o,
  output logic [7:0]  read_data_o,
  output logic        reverted_o,
  output regs_t       regs_o
);

  // architectural state
  logic [JIDX_W-1:0]        head_q;
  logic [NUM_W-1:0]         count_q;
  logic [JOURNAL_DEPTH-1:0] valid_q;
  regs_t                    ckpt_q;
  regs_t                    live_q;

  // per-transaction working registers
  logic [ADDR_BITS-1:0] addr_q;
  logic [7:0]           data_q;
  regs_t                now_q;
  reg_code_e            scan_q;
  logic [JIDX_W-1:0]    cur_q;
  logic [NUM_W-1:0]     target_q;
  logic                 first_q;

  // result registers
  logic       strobe_q;
  logic       res_kind_q;
  logic [7:0] res_data_q;
  logic       res_rev_q;
  regs_t      res_regs_q;

  // memories
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]           mem_wdata;
  logic [7:0]           mem_rdata;
  logic                 jr_we;
  jentry_t              jr_wdata;
  logic [JIDX_W-1:0]    jr_raddr;
  jentry_t              jr_rdata;

  jentry_t entry;
  logic    scan_diff;
  logic    hit;
  logic    apply;

  assign scan_diff = reg_byte(now_q, scan_q) != reg_byte(ckpt_q, scan_q);
  assign entry     = valid_q[cur_q] ? jr_rdata : '0;
  assign hit       = first_q ? (entry.num != '0) : (entry.num == target_q);
  assign apply     = cmd_i.sb_step && hit;

  assign stat_o.scan_last = (scan_q == REG_PCL);
  assign stat_o.sb_stop   = !hit;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_i[ADDR_BITS-1:0];
    mem_wdata = data_i;
    if (cmd_i.log_write) begin
      mem_we    = 1'b1;
      mem_waddr = addr_q;
      mem_wdata = data_q;
    end else if (apply && !entry.is_reg) begin
      mem_we    = 1'b1;
      mem_waddr = entry.loc;
      mem_wdata = entry.old;
    end else if (cmd_i.mem_load) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    jr_we    = 1'b0;
    jr_wdata = '0;
    if (cmd_i.log_write) begin
      jr_we    = 1'b1;
      jr_wdata = '{is_reg: 1'b0, loc: addr_q, old: mem_rdata, num: count_q};
    end else if (cmd_i.end_step && scan_diff) begin
      jr_we    = 1'b1;
      jr_wdata = '{is_reg: 1'b1,
                   loc: {{(ADDR_BITS-3){1'b0}}, scan_q},
                   old: reg_byte(ckpt_q, scan_q),
                   num: count_q};
    end
    // walk reads one entry ahead of the one being checked
    jr_raddr = cmd_i.sb_step ? jidx_prev(cur_q) : jidx_prev(head_q);
  end

  ujm_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (addr_i[ADDR_BITS-1:0]),
    .rdata_o (mem_rdata)
  );

  ujm_ram #(.WIDTH($bits(jentry_t)), .DEPTH(JOURNAL_DEPTH)) u_journal_ram (
    .clk_i   (clk_i),
    .we_i    (jr_we),
    .waddr_i (head_q),
    .wdata_i (jr_wdata),
    .raddr_i (jr_raddr),
    .rdata_o (jr_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      valid_q  <= '0;
      ckpt_q   <= '0;
      live_q   <= '0;
      first_q  <= 1'b0;
      scan_q   <= REG_ACC;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      if (jr_we) begin
        valid_q[head_q] <= 1'b1;
        head_q          <= jidx_next(head_q);
      end
      if (cmd_i.begin_instr) begin
        count_q <= count_q + NUM_W'(1);
        ckpt_q  <= regs_i;
        live_q  <= regs_i;
      end
      if (cmd_i.end_start) begin
        scan_q <= REG_ACC;
      end
      if (cmd_i.end_step) begin
        scan_q <= reg_code_e'(scan_q + 3'd1);
        if (scan_q == REG_PCL) begin
          live_q <= now_q;
        end
      end
      if (cmd_i.sb_start) begin
        first_q <= 1'b1;
      end
      if (apply) begin
        first_q        <= 1'b0;
        valid_q[cur_q] <= 1'b0;
        head_q         <= cur_q;
        count_q        <= entry.num;
        if (entry.is_reg) begin
          live_q <= reg_put(live_q, reg_code_e'(entry.loc[2:0]), entry.old);
        end
      end
      if (cmd_i.emit_read || (cmd_i.sb_step && !hit)) begin
        strobe_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      addr_q <= addr_i[ADDR_BITS-1:0];
      data_q <= data_i;
      now_q  <= regs_i;
    end
    if (cmd_i.sb_start) begin
      cur_q <= jidx_prev(head_q);
    end
    if (apply) begin
      cur_q    <= jidx_prev(cur_q);
      target_q <= entry.num;
    end
    if (cmd_i.emit_read) begin
      res_kind_q <= 1'b0;
      res_data_q <= mem_rdata;
      res_rev_q  <= 1'b0;
      res_regs_q <= '0;
    end else if (cmd_i.sb_step && !hit) begin
      res_kind_q <= 1'b1;
      res_data_q <= 8'd0;
      res_rev_q  <= !first_q;
      res_regs_q <= live_q;
    end
  end

  assign strobe_o      = strobe_q;
  assign result_kind_o = res_kind_q;
  assign read_data_o   = res_data_q;
  assign reverted_o    = res_rev_q;
  assign regs_o        = res_regs_q;

endmodule

// ----- design/undo_journal_memory.sv -----
// Top level of the undo journal memory: byte store with a ring-buffer journal
// for stepping a processor backward. Depends on ujm_pkg, ujm_ctrl, ujm_dp.
//
//  channel   | ports                          | transfer
//  ----------+--------------------------------+--------------------------------
//  command   | start_i, busy_o, kind_i .. pc  | start_i high while busy_o low
//  result    | result_strobe_o, result_*_o    | one-cycle strobe, no back-pressure
//
// Transactions: load, begin and unused kinds finish on acceptance; logged write and read
// pass through one further state; end instruction scans each register byte in turn, with
// one journal write slot per register byte; step back undoes journal entries one per
// cycle over the journal's single read port. A result strobes in the first cycle with busy_o low.
// Reset is asynchronous and takes effect at once: journal valid bits clear
// together, so no clearing pass follows. The result side cannot stall.
module undo_journal_memory import ujm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  data_i,
  input  logic [7:0]  in_acc_i,
  input  logic [7:0]  in_index_x_i,
  input  logic [7:0]  in_index_y_i,
  input  logic [7:0]  in_stack_ptr_i,
  input  logic [7:0]  in_flags_i,
  input  logic [15:0] in_prog_counter_i,
  output logic        result_strobe_o,
  output logic        result_kind_o,
  output logic [7:0]  read_data_o,
  output logic        reverted_o,
  output logic [7:0]  out_acc_o,
  output logic [7:0]  out_index_x_o,
  output logic [7:0]  out_index_y_o,
  output logic [7:0]  out_stack_ptr_o,
  output logic [7:0]  out_flags_o,
  output logic [15:0] out_prog_counter_o
);

  cmd_t  cmd;
  stat_t stat;
  regs_t regs_in;
  regs_t regs_out;

  assign regs_in = '{acc: in_acc_i, x: in_index_x_i, y: in_index_y_i,
                     sp: in_stack_ptr_i, flags: in_flags_i, pc: in_prog_counter_i};

  ujm_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .kind_i  (kind_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  ujm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .addr_i        (addr_i),
    .data_i        (data_i),
    .regs_i        (regs_in),
    .strobe_o      (result_strobe_o),
    .result_kind_o (result_kind_o),
    .read_data_o   (read_data_o),
    .reverted_o    (reverted_o),
    .regs_o        (regs_out)
  );

  assign out_acc_o          = regs_out.acc;
  assign out_index_x_o      = regs_out.x;
  assign out_index_y_o      = regs_out.y;
  assign out_stack_ptr_o    = regs_out.sp;
  assign out_flags_o        = regs_out.flags;
  assign out_prog_counter_o = regs_out.pc;

endmodule
